// File: hdl/binomial_coefficient_mod_prime_core_macros.svh
// Assertion macros for the binomial coefficient core
`ifndef BINOMIAL_COEFFICIENT_MOD_PRIME_CORE_MACROS_SVH
`define BINOMIAL_COEFFICIENT_MOD_PRIME_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define BCM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define BCM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/bcm_pkg.sv
// Shared constants, codes and control structs for the binomial coefficient core
`default_nettype none

package bcm_pkg;

  // Field widths
  localparam int MOD_W       = 30;
  localparam int ARG_BITS    = 21;
  localparam int IN_TDATA_W  = ((2 * ARG_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((MOD_W + 7) / 8) * 8;

  // Modulus after reset
  localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(1000000007);

  // Bit-serial multiplier step counter
  localparam int STEP_W = $clog2(MOD_W);

  // Multiplier operand / destination selection
  typedef logic [2:0] mul_sel_t;
  localparam mul_sel_t SEL_NMOD = 3'd0;  // 1 * n   -> n residue
  localparam mul_sel_t SEL_RMOD = 3'd1;  // 1 * r   -> r residue
  localparam mul_sel_t SEL_NUM  = 3'd2;  // num * n residue -> num
  localparam mul_sel_t SEL_DEN  = 3'd3;  // den * r residue -> den
  localparam mul_sel_t SEL_ACC  = 3'd4;  // acc * sq -> acc
  localparam mul_sel_t SEL_SQ   = 3'd5;  // sq * sq  -> sq
  localparam mul_sel_t SEL_OUT  = 3'd6;  // num * acc -> product

  // Result kind loaded into the output register
  typedef logic [1:0] res_kind_t;
  localparam res_kind_t RES_PROD  = 2'd0;
  localparam res_kind_t RES_ZERO  = 2'd1;
  localparam res_kind_t RES_UNDEF = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic      load;
    logic      mul_start;
    mul_sel_t  mul_sel;
    logic      dec;
    logic      pow_init;
    logic      exp_shift;
    logic      out_load;
    res_kind_t res_kind;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic mul_busy;
    logic mul_done;
    logic cnt_zero;
    logic den_zero;
    logic exp_zero;
    logic exp_lsb;
    logic r_gt_n;
    logic m_small;
  } stat_t;

endpackage

`default_nettype wire

// File: hdl/binomial_coefficient_mod_prime_core.sv
// Top level: binomial coefficient modulo a configurable prime
//
//  channel  dir  transfer                 payload
//  in_      in   in_tvalid & in_tready    tdata: n_value[20:0], r_value[41:21]
//  out_     out  out_tvalid & out_tready  tdata: coefficient[29:0]; tuser: inverse_undefined
//  cfg_     in   cfg_wr_en                cfg_wr_data: modulus[29:0]
//
//  A bit-serial multiply holds its state through start, 30 bit steps and write-back.
//  An r above n or a modulus below 2 goes straight to the result, with no multiply.
//  One item is worked at a time; the next is taken as soon as its result is in the
//  output register, even while that result waits for out_tready.
//  Reset is synchronous, active low, and sets the modulus to 1000000007.
`default_nettype none
`include "binomial_coefficient_mod_prime_core_macros.svh"

module binomial_coefficient_mod_prime_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // n_value [20:0], r_value [41:21], zero fill above
  input  wire logic [bcm_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // coefficient [29:0], zero fill above
  output logic [bcm_pkg::OUT_TDATA_W-1:0]      out_tdata,
  // inverse_undefined [0]
  output logic                                 out_tuser,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic                            cfg_wr_en,
  input  wire logic [bcm_pkg::MOD_W-1:0]       cfg_wr_data
);
  import bcm_pkg::*;

  cmd_t             cmd;
  stat_t            st;
  logic [MOD_W-1:0] coef;

  bcm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .st         (st),
    .cmd        (cmd)
  );

  bcm_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_n        (in_tdata[ARG_BITS-1:0]),
    .in_r        (in_tdata[2*ARG_BITS-1:ARG_BITS]),
    .cmd         (cmd),
    .st          (st),
    .out_coef    (coef),
    .out_flag    (out_tuser)
  );

  assign out_tdata = {{(OUT_TDATA_W-MOD_W){1'b0}}, coef};

  // Checks
  `BCM_ASSERT_IMP(a_start_idle_mul, clk, rst_n, cmd.mul_start, !st.mul_busy, "multiply started while busy")
  `BCM_ASSERT_IMP(a_ready_mul_idle, clk, rst_n, in_tready, !st.mul_busy, "input ready during a multiply")
  `BCM_ASSERT_IMP(a_undef_zero, clk, rst_n, out_tvalid && out_tuser, out_tdata == '0, "flagged result not zero")
  `BCM_ASSERT_NXT(a_accept_busy, clk, rst_n, in_tvalid && in_tready, !in_tready, "ready held after transfer")

endmodule

`default_nettype wire

// File: hdl/bcm_mulmod.sv
// Bit-serial modular multiplier: a * b mod m, one bit of b per cycle
`default_nettype none

module bcm_mulmod (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic [bcm_pkg::MOD_W-1:0] a,
  input  wire logic [bcm_pkg::MOD_W-1:0] b,
  input  wire logic [bcm_pkg::MOD_W-1:0] m,
  output logic                          busy,
  output logic                          done,
  output logic [bcm_pkg::MOD_W-1:0]     result
);
  import bcm_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [MOD_W-1:0]  acc_r;
  logic [MOD_W-1:0]  a_r;
  logic [MOD_W-1:0]  b_r;

  logic [MOD_W:0] dbl;
  logic [MOD_W:0] dbl_red;
  logic [MOD_W:0] sum;
  logic [MOD_W:0] sum_red;

  // One step: acc = 2*acc + bit*a, reduced by one compare-subtract each
  always_comb begin
    dbl     = {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, m}) ? (dbl - {1'b0, m}) : dbl;
    sum     = {1'b0, dbl_red[MOD_W-1:0]} + (b_r[MOD_W-1] ? {1'b0, a_r} : '0);
    sum_red = (sum >= {1'b0, m}) ? (sum - {1'b0, m}) : sum;
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= busy_r && (step_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(MOD_W - 1);
      end else if (busy_r) begin
        if (step_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          step_r <= step_r - STEP_W'(1);
        end
      end
    end
  end

  // Operands and accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      a_r   <= a;
      b_r   <= b;
    end else if (busy_r) begin
      acc_r <= sum_red[MOD_W-1:0];
      b_r   <= {b_r[MOD_W-2:0], 1'b0};
    end
  end

  assign busy   = busy_r;
  assign done   = done_r;
  assign result = acc_r;

endmodule

`default_nettype wire

// File: hdl/bcm_dp.sv
// Datapath: modulus register, operand registers, multiplier and result register
`default_nettype none

module bcm_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [bcm_pkg::MOD_W-1:0]    cfg_wr_data,
  input  wire logic [bcm_pkg::ARG_BITS-1:0] in_n,
  input  wire logic [bcm_pkg::ARG_BITS-1:0] in_r,
  input  wire bcm_pkg::cmd_t               cmd,
  output bcm_pkg::stat_t                   st,
  output logic [bcm_pkg::MOD_W-1:0]        out_coef,
  output logic                             out_flag
);
  import bcm_pkg::*;

  logic [MOD_W-1:0]    modulus_r;
  logic [ARG_BITS-1:0] n_r;
  logic [ARG_BITS-1:0] r_r;
  logic [ARG_BITS-1:0] cnt_r;
  logic [MOD_W-1:0]    nmod_r;
  logic [MOD_W-1:0]    rmod_r;
  logic [MOD_W-1:0]    num_r;
  logic [MOD_W-1:0]    den_r;
  logic [MOD_W-1:0]    acc_r;
  logic [MOD_W-1:0]    sq_r;
  logic [MOD_W-1:0]    exp_r;
  logic [MOD_W-1:0]    prod_r;
  logic [MOD_W-1:0]    coef_r;
  logic                flag_r;

  logic [MOD_W-1:0] mul_a;
  logic [MOD_W-1:0] mul_b;
  logic             mul_busy;
  logic             mul_done;
  logic [MOD_W-1:0] mul_res;
  logic [MOD_W-1:0] mod_less1;

  assign mod_less1 = modulus_r - MOD_W'(1);

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MOD_RESET;
    end else if (cfg_wr_en) begin
      modulus_r <= cfg_wr_data;
    end
  end

  // Multiplier operand select
  always_comb begin
    unique case (cmd.mul_sel)
      SEL_NMOD: begin mul_a = MOD_W'(1); mul_b = MOD_W'(n_r); end
      SEL_RMOD: begin mul_a = MOD_W'(1); mul_b = MOD_W'(r_r); end
      SEL_NUM:  begin mul_a = num_r;     mul_b = nmod_r;      end
      SEL_DEN:  begin mul_a = den_r;     mul_b = rmod_r;      end
      SEL_ACC:  begin mul_a = acc_r;     mul_b = sq_r;        end
      SEL_SQ:   begin mul_a = sq_r;      mul_b = sq_r;        end
      SEL_OUT:  begin mul_a = num_r;     mul_b = acc_r;       end
      default:  begin mul_a = '0;        mul_b = '0;          end
    endcase
  end

  bcm_mulmod u_mulmod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmd.mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .m      (modulus_r),
    .busy   (mul_busy),
    .done   (mul_done),
    .result (mul_res)
  );

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r   <= in_n;
      r_r   <= in_r;
      cnt_r <= in_r;
      num_r <= MOD_W'(1);
      den_r <= MOD_W'(1);
    end
    // multiplier write-back, destination held by the controller
    if (mul_done) begin
      unique case (cmd.mul_sel)
        SEL_NMOD: nmod_r <= mul_res;
        SEL_RMOD: rmod_r <= mul_res;
        SEL_NUM:  num_r  <= mul_res;
        SEL_DEN:  den_r  <= mul_res;
        SEL_ACC:  acc_r  <= mul_res;
        SEL_SQ:   sq_r   <= mul_res;
        SEL_OUT:  prod_r <= mul_res;
        default:  prod_r <= prod_r;
      endcase
    end
    // step both factors down, residues wrap at zero
    if (cmd.dec) begin
      cnt_r  <= cnt_r - ARG_BITS'(1);
      nmod_r <= (nmod_r == '0) ? mod_less1 : (nmod_r - MOD_W'(1));
      rmod_r <= (rmod_r == '0) ? mod_less1 : (rmod_r - MOD_W'(1));
    end
    // Fermat inverse setup: exponent modulus - 2
    if (cmd.pow_init) begin
      acc_r <= MOD_W'(1);
      sq_r  <= den_r;
      exp_r <= modulus_r - MOD_W'(2);
    end
    if (cmd.exp_shift) begin
      exp_r <= exp_r >> 1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      unique case (cmd.res_kind)
        RES_PROD:  begin coef_r <= prod_r; flag_r <= 1'b0; end
        RES_UNDEF: begin coef_r <= '0;     flag_r <= 1'b1; end
        default:   begin coef_r <= '0;     flag_r <= 1'b0; end
      endcase
    end
  end

  // Status
  always_comb begin
    st.mul_busy = mul_busy;
    st.mul_done = mul_done;
    st.cnt_zero = (cnt_r == '0);
    st.den_zero = (den_r == '0);
    st.exp_zero = (exp_r == '0);
    st.exp_lsb  = exp_r[0];
    st.r_gt_n   = (r_r > n_r);
    st.m_small  = (modulus_r < MOD_W'(2));
  end

  assign out_coef = coef_r;
  assign out_flag = flag_r;

endmodule

`default_nettype wire

// File: hdl/bcm_ctrl.sv
// Controller: sequences products, inverse and result transfer
`default_nettype none

module bcm_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  input  wire bcm_pkg::stat_t st,
  output bcm_pkg::cmd_t       cmd
);
  import bcm_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_CHECK  = 4'd1;
  localparam logic [3:0] ST_NMOD   = 4'd2;
  localparam logic [3:0] ST_RMOD   = 4'd3;
  localparam logic [3:0] ST_LOOP   = 4'd4;
  localparam logic [3:0] ST_NUM    = 4'd5;
  localparam logic [3:0] ST_DEN    = 4'd6;
  localparam logic [3:0] ST_DENCHK = 4'd7;
  localparam logic [3:0] ST_POW    = 4'd8;
  localparam logic [3:0] ST_PACC   = 4'd9;
  localparam logic [3:0] ST_PSQ    = 4'd10;
  localparam logic [3:0] ST_FINAL  = 4'd11;
  localparam logic [3:0] ST_DONE   = 4'd12;

  logic [3:0] state_r, state_nxt;
  logic       issued_r, issued_nxt;
  logic       out_valid_r, out_valid_nxt;
  res_kind_t  kind_r, kind_nxt;

  logic       mul_act;
  logic [3:0] mul_next;

  always_comb begin
    cmd           = '0;
    cmd.mul_sel   = SEL_NMOD;
    cmd.res_kind  = kind_r;
    state_nxt     = state_r;
    issued_nxt    = issued_r;
    kind_nxt      = kind_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mul_act       = 1'b0;
    mul_next      = state_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        priority if (st.r_gt_n) begin
          kind_nxt  = RES_ZERO;
          state_nxt = ST_DONE;
        end else if (st.m_small) begin
          kind_nxt  = RES_UNDEF;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_NMOD;
        end
      end
      ST_NMOD: begin
        cmd.mul_sel = SEL_NMOD; mul_act = 1'b1; mul_next = ST_RMOD;
      end
      ST_RMOD: begin
        cmd.mul_sel = SEL_RMOD; mul_act = 1'b1; mul_next = ST_LOOP;
      end
      ST_LOOP: begin
        state_nxt = st.cnt_zero ? ST_DENCHK : ST_NUM;
      end
      ST_NUM: begin
        cmd.mul_sel = SEL_NUM; mul_act = 1'b1; mul_next = ST_DEN;
      end
      ST_DEN: begin
        cmd.mul_sel = SEL_DEN; mul_act = 1'b1; mul_next = ST_LOOP;
        cmd.dec     = st.mul_done;
      end
      ST_DENCHK: begin
        if (st.den_zero) begin
          kind_nxt  = RES_UNDEF;
          state_nxt = ST_DONE;
        end else begin
          cmd.pow_init = 1'b1;
          state_nxt    = ST_POW;
        end
      end
      ST_POW: begin
        priority if (st.exp_zero) begin
          state_nxt = ST_FINAL;
        end else if (st.exp_lsb) begin
          state_nxt = ST_PACC;
        end else begin
          state_nxt = ST_PSQ;
        end
      end
      ST_PACC: begin
        cmd.mul_sel = SEL_ACC; mul_act = 1'b1; mul_next = ST_PSQ;
      end
      ST_PSQ: begin
        cmd.mul_sel   = SEL_SQ; mul_act = 1'b1; mul_next = ST_POW;
        cmd.exp_shift = st.mul_done;
      end
      ST_FINAL: begin
        cmd.mul_sel = SEL_OUT; mul_act = 1'b1; mul_next = ST_DONE;
        if (st.mul_done) kind_nxt = RES_PROD;
      end
      ST_DONE: begin
        // load the output register once the previous result has left
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Shared multiply handshake: start once, advance on done
    if (mul_act) begin
      cmd.mul_start = !issued_r;
      if (!issued_r) issued_nxt = 1'b1;
      if (st.mul_done) begin
        issued_nxt = 1'b0;
        state_nxt  = mul_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      kind_r      <= RES_ZERO;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
      kind_r      <= kind_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire
